FILE: src/scba_pkg.sv
// ----------------------------------------------------------------------------
// scba_pkg
// Shared types and constants for the size-class bitmap allocator: the class
// layout, field widths, request and status codes, and the sequencer states.
// ----------------------------------------------------------------------------
package scba_pkg;

  // Field widths
  localparam int unsigned SIZE_W  = 16;
  localparam int unsigned ADDR_W  = 17;
  localparam int unsigned CLS_W   = 3;
  localparam int unsigned SLOT_W  = 6;
  localparam int unsigned CFG_W   = 7;

  // Reset value of the slots-in-use register
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  // Size classes
  localparam int unsigned N_CLASSES = 5;
  localparam int unsigned MAX_SIZE  = 1024;

  // log2 of the slot size of each class
  localparam int unsigned CLASS_SHIFT [N_CLASSES] = '{4, 6, 8, 9, 10};
  // Slot size of each class in bytes
  localparam int unsigned CLASS_SIZE [N_CLASSES] = '{16, 64, 256, 512, 1024};
  // Start of each class region, in units of the per-class slot count
  localparam int unsigned CLASS_PRE [N_CLASSES] = '{0, 16, 80, 336, 848};
  // End of the last region, in the same units
  localparam int unsigned CLASS_END = 1872;

  // Request kinds
  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_ALLOC   = 2'd0,
    ST_FAIL    = 2'd1,
    ST_FREED   = 2'd2,
    ST_IGNORED = 2'd3
  } status_e;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_ALLOC = 2'd1,
    S_FREE  = 2'd2,
    S_DONE  = 2'd3
  } state_e;

endpackage

FILE: src/size_class_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// size_class_bitmap_allocator
// Fixed-pool slab allocator with five size classes, each tracked by a free
// bitmap that a small sequencer scans one byte-wide chunk per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_axis_* carries requests: tuser is the opcode (0 allocate,
//   1 free), tdata holds the request size and the address being released.
//   Master stream m_axis_* returns one result per request: tuser is the
//   status, tdata holds the block address, the class and the slot index.
//   cfg_we_i/cfg_wdata_i write the slots-in-use limit; write it only while
//   no request is in flight.
// Throughput:
//   One request is handled at a time; s_axis_tready_o is high only while the
//   sequencer is idle. A free walks the classes one per cycle. An allocate
//   walks the classes and, within a fitting class, the free bitmap eight
//   slots per cycle through one shared chunk scanner and address adder. A
//   request above 1024 bytes fails without a class walk.
// Reset:
//   Every slot is free, the limit is 64, the output stream is empty.
// Stall:
//   A finished result waits in the output register; a next result waits in
//   the sequencer's done state until the receiver takes the previous one.
// ----------------------------------------------------------------------------
module size_class_bitmap_allocator #(
  parameter int SLOTS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: slots_in_use
  input  logic                        cfg_we_i,
  input  logic [scba_pkg::CFG_W-1:0]  cfg_wdata_i,
  // Requests
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // [15:0] request_size, [32:16] free_address
  input  logic        s_axis_tuser_i,   // [0] opcode
  // Results
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [16:0] block_address, [19:17] size_class,
                                        // [25:20] slot_index
  output logic [1:0]  m_axis_tuser_o    // [1:0] status
);
  import scba_pkg::*;

  // Bitmap geometry: chunks of eight slots, padded to a power of two
  localparam int NCHUNK = (SLOTS + 7) / 8;
  localparam int CW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int PW     = CW + 3;
  localparam int PAD    = 1 << PW;
  localparam int NW     = PW + 1;
  localparam int NCW    = (NW > CFG_W) ? NW : CFG_W;
  // Internal address width, wide enough for every region
  localparam int SPAN_W = $clog2(SLOTS * CLASS_END + 1);
  localparam int XW     = (SPAN_W > ADDR_W) ? SPAN_W : ADDR_W;

  localparam logic [XW-1:0] CLASS_BASE [N_CLASSES] = '{
    XW'(SLOTS * CLASS_PRE[0]), XW'(SLOTS * CLASS_PRE[1]), XW'(SLOTS * CLASS_PRE[2]),
    XW'(SLOTS * CLASS_PRE[3]), XW'(SLOTS * CLASS_PRE[4])
  };

  // State
  state_e                              state_q, state_d;
  logic [N_CLASSES-1:0][PAD-1:0]       free_map_q, free_map_d;
  logic [CFG_W-1:0]                    cfg_q;
  logic                                op_q, op_d;
  logic [SIZE_W-1:0]                   size_q, size_d;
  logic [ADDR_W-1:0]                   addr_q, addr_d;
  logic [CLS_W-1:0]                    cls_q, cls_d;
  logic [CW-1:0]                       chunk_q, chunk_d;
  // Pending result
  status_e                             res_status_q, res_status_d;
  logic [ADDR_W-1:0]                   res_addr_q, res_addr_d;
  logic [CLS_W-1:0]                    res_cls_q, res_cls_d;
  logic [SLOT_W-1:0]                   res_slot_q, res_slot_d;
  // Output register
  logic                                m_valid_q, m_valid_d;
  logic [1:0]                          out_status_q, out_status_d;
  logic [ADDR_W-1:0]                   out_addr_q, out_addr_d;
  logic [CLS_W-1:0]                    out_cls_q, out_cls_d;
  logic [SLOT_W-1:0]                   out_slot_q, out_slot_d;

  // Shared datapath
  logic [NCW-1:0]     cfg_ext;
  logic [NW-1:0]      n_act;
  logic [7:0]         chunk_bits;
  logic [7:0]         avail;
  logic [2:0]         hit_j;
  logic               hit_any;
  logic [PW-1:0]      alloc_slot;
  logic [NW-1:0]      next_start;
  logic               chunk_last;
  logic               class_fits;
  logic               class_end;
  logic [XW-1:0]      class_base;
  logic [XW-1:0]      alloc_addr;
  logic [XW-1:0]      addr_x;
  logic [XW-1:0]      free_slot_w;
  logic               free_hit;
  logic [CLS_W-1:0]   cls_idx;

  // Clamp the limit to the pool size
  always_comb begin
    cfg_ext = NCW'(cfg_q);
    n_act   = (cfg_ext > NCW'(SLOTS)) ? NW'(SLOTS) : NW'(cfg_ext);
  end

  // Chunk scanner: lowest free slot of the current chunk below the limit
  always_comb begin
    cls_idx    = cls_q;
    class_end  = (cls_q == CLS_W'(N_CLASSES));
    class_base = class_end ? '0 : CLASS_BASE[cls_idx];
    class_fits = !class_end && (size_q <= SIZE_W'(CLASS_SIZE[cls_idx]));
    chunk_bits = class_end ? '0 : free_map_q[cls_idx][{chunk_q, 3'b000} +: 8];
    for (int j = 0; j < 8; j++) begin
      avail[j] = chunk_bits[j] && (NW'({chunk_q, 3'(j)}) < n_act);
    end
    hit_any = |avail;
    hit_j   = '0;
    for (int j = 7; j >= 0; j--) begin
      if (avail[j]) begin
        hit_j = 3'(j);
      end
    end
    alloc_slot = {chunk_q, hit_j};
    next_start = {({1'b0, chunk_q} + (CW+1)'(1)), 3'b000};
    chunk_last = (next_start >= n_act);
    alloc_addr = class_base + (XW'(alloc_slot) << CLASS_SHIFT[cls_idx]);
  end

  // Range check: slot of the address within the current class
  always_comb begin
    addr_x      = XW'(addr_q);
    free_slot_w = (addr_x - class_base) >> CLASS_SHIFT[cls_idx];
    free_hit    = !class_end && (addr_x >= class_base) && (free_slot_w < XW'(n_act));
  end

  // Sequencer: next state and datapath control
  always_comb begin
    state_d      = state_q;
    free_map_d   = free_map_q;
    op_d         = op_q;
    size_d       = size_q;
    addr_d       = addr_q;
    cls_d        = cls_q;
    chunk_d      = chunk_q;
    res_status_d = res_status_q;
    res_addr_d   = res_addr_q;
    res_cls_d    = res_cls_q;
    res_slot_d   = res_slot_q;
    m_valid_d    = m_valid_q && !m_axis_tready_i;
    out_status_d = out_status_q;
    out_addr_d   = out_addr_q;
    out_cls_d    = out_cls_q;
    out_slot_d   = out_slot_q;
    s_axis_tready_o = (state_q == S_IDLE);

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          op_d    = s_axis_tuser_i;
          size_d  = s_axis_tdata_i[15:0];
          addr_d  = s_axis_tdata_i[32:16];
          cls_d   = '0;
          chunk_d = '0;
          res_addr_d = '0;
          res_cls_d  = '0;
          res_slot_d = '0;
          if (s_axis_tuser_i == OP_FREE) begin
            state_d = S_FREE;
          end else if (s_axis_tdata_i[15:0] > SIZE_W'(MAX_SIZE)) begin
            res_status_d = ST_FAIL;
            state_d      = S_DONE;
          end else begin
            state_d = S_ALLOC;
          end
        end
      end
      S_ALLOC: begin
        priority if (class_end) begin
          res_status_d = ST_FAIL;
          state_d      = S_DONE;
        end else if (class_fits && hit_any) begin
          // Take the slot and report its address
          free_map_d[cls_idx][alloc_slot] = 1'b0;
          res_status_d = ST_ALLOC;
          res_addr_d   = alloc_addr[ADDR_W-1:0];
          res_cls_d    = cls_q;
          res_slot_d   = SLOT_W'(alloc_slot);
          state_d      = S_DONE;
        end else if (!class_fits || chunk_last) begin
          cls_d   = cls_q + CLS_W'(1);
          chunk_d = '0;
        end else begin
          chunk_d = chunk_q + CW'(1);
        end
      end
      S_FREE: begin
        priority if (class_end) begin
          res_status_d = ST_IGNORED;
          state_d      = S_DONE;
        end else if (free_hit) begin
          free_map_d[cls_idx][free_slot_w[PW-1:0]] = 1'b1;
          res_status_d = ST_FREED;
          res_cls_d    = cls_q;
          res_slot_d   = SLOT_W'(free_slot_w[PW-1:0]);
          state_d      = S_DONE;
        end else begin
          cls_d = cls_q + CLS_W'(1);
        end
      end
      S_DONE: begin
        // Hand the result over once the output register is free
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d    = 1'b1;
          out_status_d = res_status_q;
          out_addr_d   = res_addr_q;
          out_cls_d    = res_cls_q;
          out_slot_d   = res_slot_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      free_map_q <= '1;
      cfg_q      <= CFG_RESET;
      m_valid_q  <= 1'b0;
      cls_q      <= '0;
    end else begin
      state_q    <= state_d;
      free_map_q <= free_map_d;
      m_valid_q  <= m_valid_d;
      cls_q      <= cls_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    size_q       <= size_d;
    addr_q       <= addr_d;
    chunk_q      <= chunk_d;
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    res_cls_q    <= res_cls_d;
    res_slot_q   <= res_slot_d;
    out_status_q <= out_status_d;
    out_addr_q   <= out_addr_d;
    out_cls_q    <= out_cls_d;
    out_slot_q   <= out_slot_d;
  end

  // Drive the result stream
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = {6'b0, out_slot_q, out_cls_q, out_addr_q};

  // Assertions
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("request accepted while the sequencer was busy");

  a_class_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cls_q <= CLS_W'(N_CLASSES))
    else $error("class walk ran past the last class");

  a_alloc_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == ST_ALLOC || m_axis_tuser_o == ST_FREED)
    |-> m_axis_tdata_o[19:17] < CLS_W'(N_CLASSES))
    else $error("result reports a class that does not exist");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == ST_FAIL || m_axis_tuser_o == ST_IGNORED)
    |-> m_axis_tdata_o == '0)
    else $error("failed or ignored result carries nonzero fields");

  a_op_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ALLOC) |-> (op_q == OP_ALLOC))
    else $error("allocate scan running for a free request");

endmodule
